// ===== sv/risc_subset_instruction_executor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer subset executor
// Immediate and next-cycle implications, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RISC_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define RISC_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RSIE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define RSIE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rsie_pkg.sv =====
// ----------------------------------------------------------------------------
// rsie_pkg
// Shared types, instruction codes and constants of the subset executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsie_pkg;

	localparam int unsigned MEM_WORDS_DEFAULT = 1024;
	localparam logic [31:0] MEM_BASE          = 32'h0040_0000;
	localparam logic [31:0] START_PC_RESET    = MEM_BASE;

	localparam int unsigned NUM_REGS = 32;
	localparam int unsigned REG_AW   = 5;

	// Configuration register map
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned APB_AW    = CFG_IDX_W + 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_PC = '0;

	// Item opcodes
	localparam logic ITEM_EXEC    = 1'b0;
	localparam logic ITEM_PRELOAD = 1'b1;

	// Primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	// Function codes under OP_SPECIAL
	localparam logic [5:0] FN_SLL  = 6'd0;
	localparam logic [5:0] FN_SRL  = 6'd2;
	localparam logic [5:0] FN_JR   = 6'd8;
	localparam logic [5:0] FN_ADDU = 6'd33;
	localparam logic [5:0] FN_SUBU = 6'd35;
	localparam logic [5:0] FN_AND  = 6'd36;
	localparam logic [5:0] FN_OR   = 6'd37;
	localparam logic [5:0] FN_SLT  = 6'd42;

	localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
	localparam logic [REG_AW-1:0] REG_LINK = 5'd31;

	// Fault codes
	localparam logic [1:0] FAULT_NONE        = 2'd0;
	localparam logic [1:0] FAULT_UNSUPPORTED = 2'd1;
	localparam logic [1:0] FAULT_RANGE       = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [31:0] instr_word;
		logic [9:0]  load_index;
		logic [31:0] load_data;
	} item_t;

	typedef struct packed {
		logic [31:0]       next_pc;
		logic              reg_written;
		logic [REG_AW-1:0] dest_reg;
		logic [31:0]       written_value;
		logic              mem_written;
		logic [31:0]       mem_address;
		logic [1:0]        fault;
	} result_t;

	// Outcome of the execute stage, before the load data is known
	typedef struct packed {
		logic [1:0]        fault;
		logic [31:0]       next_pc;
		logic              reg_we;
		logic [REG_AW-1:0] dest_reg;
		logic [31:0]       reg_value;
		logic              is_load;
		logic              mem_we;
		logic [31:0]       mem_addr;
		logic [31:0]       mem_value;
	} exec_t;

	typedef struct packed {
		logic              we;
		logic [REG_AW-1:0] addr;
		logic [31:0]       data;
	} rf_wr_t;

endpackage

// ===== sv/rsie_regfile.sv =====
// ----------------------------------------------------------------------------
// rsie_regfile
// 32 x 32 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsie_regfile (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [rsie_pkg::REG_AW-1:0] rd_addr_a,
	input  logic [rsie_pkg::REG_AW-1:0] rd_addr_b,
	input  rsie_pkg::rf_wr_t          wr,
	output logic [31:0]               rd_data_a,
	output logic [31:0]               rd_data_b
);
	import rsie_pkg::*;

	logic [31:0]         mem [NUM_REGS];
	logic [NUM_REGS-1:0] written_q;
	logic [31:0]         data_a_q;
	logic [31:0]         data_b_q;
	logic                hit_a_q;
	logic                hit_b_q;

	// Read returns the old contents when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			data_a_q <= mem[rd_addr_a];
			data_b_q <= mem[rd_addr_b];
		end
	end

	// An entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_a_q   <= 1'b0;
			hit_b_q   <= 1'b0;
		end else begin
			if (wr.we) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_a_q <= written_q[rd_addr_a];
				hit_b_q <= written_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = hit_a_q ? data_a_q : '0;
	assign rd_data_b = hit_b_q ? data_b_q : '0;

endmodule

// ===== sv/rsie_dmem.sv =====
// ----------------------------------------------------------------------------
// rsie_dmem
// Data memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsie_dmem #(
	parameter  int unsigned MEM_WORDS = rsie_pkg::MEM_WORDS_DEFAULT,
	localparam int unsigned AW        = $clog2(MEM_WORDS)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_idx,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_idx,
	input  logic [31:0]   wr_data,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/rsie_exec.sv =====
// ----------------------------------------------------------------------------
// rsie_exec
// Decode and execute of one word: ALU, branch target, address range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsie_exec #(
	parameter  int unsigned MEM_WORDS = rsie_pkg::MEM_WORDS_DEFAULT,
	localparam int unsigned AW        = $clog2(MEM_WORDS)
) (
	input  rsie_pkg::item_t item,
	input  logic [31:0]     pc,
	input  logic [31:0]     opa,
	input  logic [31:0]     opb,
	output rsie_pkg::exec_t res,
	output logic [AW-1:0]   mem_idx
);
	import rsie_pkg::*;

	logic [5:0]        op;
	logic [5:0]        fn;
	logic [REG_AW-1:0] rt;
	logic [REG_AW-1:0] rd;
	logic [4:0]        sh;
	logic [15:0]       imm;
	logic [31:0]       simm;
	logic [31:0]       pc4;
	logic [31:0]       br_target;
	logic [31:0]       jmp_target;
	logic [31:0]       ea;
	logic [31:0]       ea_off;
	logic              ea_ok;
	logic              ld_ok;

	assign op   = item.instr_word[31:26];
	assign rt   = item.instr_word[20:16];
	assign rd   = item.instr_word[15:11];
	assign sh   = item.instr_word[10:6];
	assign fn   = item.instr_word[5:0];
	assign imm  = item.instr_word[15:0];
	assign simm = {{16{imm[15]}}, imm};

	assign pc4        = pc + 32'd4;
	assign br_target  = pc4 + {simm[29:0], 2'b00};
	assign jmp_target = {pc4[31:28], item.instr_word[25:0], 2'b00};

	// Effective address: in range, aligned, and below the top of memory
	assign ea     = opa + simm;
	assign ea_off = ea - MEM_BASE;
	assign ea_ok  = (ea >= MEM_BASE) && (ea[1:0] == 2'b00)
		&& ({2'b00, ea_off[31:2]} < 32'(MEM_WORDS));
	assign ld_ok  = 32'(item.load_index) < 32'(MEM_WORDS);

	assign mem_idx = (item.opcode == ITEM_PRELOAD) ? AW'(item.load_index) : ea_off[AW+1:2];

	always_comb begin
		logic [1:0]        flt;
		logic              regw;
		logic [REG_AW-1:0] wreg;
		logic [31:0]       wval;

		res     = '0;
		flt     = FAULT_NONE;
		regw    = 1'b0;
		wreg    = rt;
		wval    = '0;
		res.next_pc = pc4;

		if (item.opcode == ITEM_PRELOAD) begin
			res.next_pc = pc;
			if (ld_ok) begin
				res.mem_we    = 1'b1;
				res.mem_addr  = MEM_BASE + {20'd0, item.load_index, 2'b00};
				res.mem_value = item.load_data;
			end else begin
				flt = FAULT_RANGE;
			end
		end else begin
			unique case (op)
				OP_SPECIAL: begin
					regw = 1'b1;
					wreg = rd;
					unique case (fn)
						FN_ADDU: wval = opa + opb;
						FN_SUBU: wval = opa - opb;
						FN_SLL:  wval = opb << sh;
						FN_SRL:  wval = opb >> sh;
						FN_AND:  wval = opa & opb;
						FN_OR:   wval = opa | opb;
						FN_SLT:  wval = {31'd0, $signed(opa) < $signed(opb)};
						FN_JR: begin
							regw        = 1'b0;
							res.next_pc = opa;
						end
						default: flt = FAULT_UNSUPPORTED;
					endcase
				end
				OP_ADDIU: begin
					regw = 1'b1;
					wval = opa + simm;
				end
				OP_ANDI: begin
					regw = 1'b1;
					wval = opa & {16'd0, imm};
				end
				OP_ORI: begin
					regw = 1'b1;
					wval = opa | {16'd0, imm};
				end
				OP_LUI: begin
					regw = 1'b1;
					wval = {imm, 16'd0};
				end
				OP_BEQ: begin
					if (opa == opb) begin
						res.next_pc = br_target;
					end
				end
				OP_BNE: begin
					if (opa != opb) begin
						res.next_pc = br_target;
					end
				end
				OP_LW: begin
					if (ea_ok) begin
						regw         = 1'b1;
						res.is_load  = 1'b1;
						res.mem_addr = ea;
					end else begin
						flt = FAULT_RANGE;
					end
				end
				OP_SW: begin
					if (ea_ok) begin
						res.mem_we    = 1'b1;
						res.mem_addr  = ea;
						res.mem_value = opb;
					end else begin
						flt = FAULT_RANGE;
					end
				end
				OP_J: res.next_pc = jmp_target;
				OP_JAL: begin
					regw        = 1'b1;
					wreg        = REG_LINK;
					wval        = pc4;
					res.next_pc = jmp_target;
				end
				default: flt = FAULT_UNSUPPORTED;
			endcase
		end

		// A faulting word leaves the PC and all state alone.
		if (flt != FAULT_NONE) begin
			res         = '0;
			res.next_pc = pc;
			res.fault   = flt;
		end else begin
			res.reg_we    = regw && (wreg != REG_ZERO);
			res.dest_reg  = res.reg_we ? wreg : REG_ZERO;
			res.reg_value = wval;
		end
	end

endmodule

// ===== sv/risc_subset_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// risc_subset_instruction_executor
// A taken word moves through s1 and s2 into result_q. Throughput: one word
// per cycle unless stalled; register file and data memory are read on
// the way into a stage and written back from stage 2, with bypass paths.
// Reset: PC and start_pc to 0x00400000, pipeline empty, registers read zero;
// data memory contents stay undefined and there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "risc_subset_instruction_executor_assert.svh"

module risc_subset_instruction_executor #(
	parameter int unsigned MEM_WORDS = rsie_pkg::MEM_WORDS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input word channel
	input  logic                        item_valid,
	output logic                        item_stall,
	input  rsie_pkg::item_t             item,
	// Result word channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output rsie_pkg::result_t           result,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsie_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rsie_pkg::*;

	localparam int unsigned AW = $clog2(MEM_WORDS);

	// Pipeline:
	//   accept edge : latch word into s1, read rs/rt from the register file
	//   s1          : execute with bypassed operands, update PC, issue load read
	//   s2          : pick load data, write register file and data memory
	//   result_q    : output register holding the finished word
	// All stages advance together whenever the output register can move.

	logic        adv;

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	exec_t       res_s2;
	logic [AW-1:0] idx_s2;
	logic        result_valid_q;
	result_t     result_q;
	result_t     result_d;

	logic [31:0] pc_q;
	logic [31:0] start_pc_q;

	logic [REG_AW-1:0] rs_s1;
	logic [REG_AW-1:0] rt_s1;
	logic [31:0] rf_rdata_a;
	logic [31:0] rf_rdata_b;
	logic [31:0] opa;
	logic [31:0] opb;
	rf_wr_t      rf_wr;

	exec_t       exec_res;
	logic [AW-1:0] exec_idx;

	logic [31:0] dm_rdata;
	logic [31:0] load_data_s2;
	logic [31:0] wb_value_s2;
	logic        dm_we;
	logic        cfg_wr;

	// Advance unless a result waits and the far side holds it off.
	assign adv          = !result_valid_q || !result_stall;
	assign item_stall   = !adv;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ------------------------------------------------------------------
	// Configuration: start_pc is held for readback only; the PC resets to the
	// same constant, START_PC_RESET, and does not follow writes to start_pc.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_AW-1:2] == REG_START_PC);
	assign prdata = (paddr[APB_AW-1:2] == REG_START_PC) ? start_pc_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= START_PC_RESET;
		end else if (cfg_wr) begin
			start_pc_q <= pwdata;
		end
	end

	// ------------------------------------------------------------------
	// Register file: read at accept, written from s2
	// ------------------------------------------------------------------
	rsie_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (adv),
		.rd_addr_a (item.instr_word[25:21]),
		.rd_addr_b (item.instr_word[20:16]),
		.wr        (rf_wr),
		.rd_data_a (rf_rdata_a),
		.rd_data_b (rf_rdata_b)
	);

	assign rs_s1 = item_s1.instr_word[25:21];
	assign rt_s1 = item_s1.instr_word[20:16];

	// Bypass: the word in s2 writes after our read; the word in result_q
	// wrote on the same edge as our read, so the memory gave the old value.
	always_comb begin
		priority if (valid_s2 && res_s2.reg_we && (res_s2.dest_reg == rs_s1)) begin
			opa = wb_value_s2;
		end else if (result_valid_q && result_q.reg_written
			&& (result_q.dest_reg == rs_s1)) begin
			opa = result_q.written_value;
		end else begin
			opa = rf_rdata_a;
		end
	end

	always_comb begin
		priority if (valid_s2 && res_s2.reg_we && (res_s2.dest_reg == rt_s1)) begin
			opb = wb_value_s2;
		end else if (result_valid_q && result_q.reg_written
			&& (result_q.dest_reg == rt_s1)) begin
			opb = result_q.written_value;
		end else begin
			opb = rf_rdata_b;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: execute
	// ------------------------------------------------------------------
	rsie_exec #(
		.MEM_WORDS (MEM_WORDS)
	) u_exec (
		.item    (item_s1),
		.pc      (pc_q),
		.opa     (opa),
		.opb     (opb),
		.res     (exec_res),
		.mem_idx (exec_idx)
	);

	// ------------------------------------------------------------------
	// Data memory: load read issued from s1, writes from s2
	// ------------------------------------------------------------------
	assign dm_we = adv && valid_s2 && res_s2.mem_we;

	rsie_dmem #(
		.MEM_WORDS (MEM_WORDS)
	) u_dmem (
		.clk     (clk),
		.rd_en   (adv),
		.rd_idx  (exec_idx),
		.wr_en   (dm_we),
		.wr_idx  (idx_s2),
		.wr_data (res_s2.mem_value),
		.rd_data (dm_rdata)
	);

	// A store or preload now in result_q wrote on the edge of our read.
	assign load_data_s2 = (result_valid_q && result_q.mem_written
		&& (result_q.mem_address == res_s2.mem_addr)) ? result_q.written_value : dm_rdata;
	assign wb_value_s2  = res_s2.is_load ? load_data_s2 : res_s2.reg_value;

	assign rf_wr.we   = adv && valid_s2 && res_s2.reg_we;
	assign rf_wr.addr = res_s2.dest_reg;
	assign rf_wr.data = wb_value_s2;

	// ------------------------------------------------------------------
	// Result word
	// ------------------------------------------------------------------
	always_comb begin
		result_d.next_pc     = res_s2.next_pc;
		result_d.reg_written = res_s2.reg_we;
		result_d.dest_reg    = res_s2.dest_reg;
		result_d.mem_written = res_s2.mem_we;
		result_d.mem_address = res_s2.mem_we ? res_s2.mem_addr : '0;
		result_d.fault       = res_s2.fault;
		priority if (res_s2.reg_we) begin
			result_d.written_value = wb_value_s2;
		end else if (res_s2.mem_we) begin
			result_d.written_value = res_s2.mem_value;
		end else begin
			result_d.written_value = '0;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
			pc_q           <= START_PC_RESET;
		end else if (adv) begin
			valid_s1       <= item_valid;
			valid_s2       <= valid_s1;
			result_valid_q <= valid_s2;
			// Faults and preloads report the current PC as next_pc.
			if (valid_s1) begin
				pc_q <= exec_res.next_pc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= item;
			res_s2   <= exec_res;
			idx_s2   <= exec_idx;
			result_q <= result_d;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`RSIE_ASSERT_IMP(a_fault_no_write, result_valid_q && (result_q.fault != FAULT_NONE), !result_q.reg_written && !result_q.mem_written, "faulting word reports a write")
	`RSIE_ASSERT_IMP(a_no_zero_write, rf_wr.we, rf_wr.addr != REG_ZERO, "register zero written")
	`RSIE_ASSERT_IMP(a_store_or_reg, valid_s2 && res_s2.mem_we, !res_s2.reg_we, "word writes memory and register")
	`RSIE_ASSERT_NXT(a_pc_hold, !(adv && valid_s1), $stable(pc_q), "PC moved with no word leaving s1")

endmodule
